/* hw/rtl/bmhq_pkg.sv */
// Shared types and constants for the binary min-heap queue.
package bmhq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = ADDR_W + 2;
    localparam int CNT_W   = 11;
    localparam int KEY_W   = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    // Register index 0 is capacity; paddr[2] selects the register.
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic signed [KEY_W-1:0] KEY_MIN   = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_EMPTY = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_EXTRACT  = 3'd1,
        OP_DECREASE = 3'd2,
        OP_DELETE   = 3'd3,
        OP_CLEAR    = 3'd4
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADIDX = 3'd3,
        ST_LARGER = 3'd4
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [KEY_W-1:0] key;
        logic [ADDR_W-1:0]       position;
    } t_cmd;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        count;
    } t_result;

endpackage

/* hw/rtl/binary_min_heap_queue_core.sv */
// Binary min-heap priority queue of signed keys held in one two-read-port RAM.
//
//  channel  | signals                                  | direction | handshake
//  ---------+------------------------------------------+-----------+---------------------------
//  command  | start, i_cmd                             | in        | start & !busy
//  result   | o_done, o_result                         | out       | o_done, one cycle
//  config   | psel penable pwrite paddr pwdata prdata  | in/out    | APB, pready always high
//
// Clear, unused operations and items refused at once (full, empty, bad index) finish
// straight from idle, and a decrease that brings a larger key ends after its compare.
// Insert and decrease sift up, extract sifts down, and delete sifts up, then extracts;
// each sift walks at most log2(DEPTH) tree levels. Each sift level costs one RAM read and
// one write-back, with the next read issued in the same cycle.
// Reset clears the count and sets capacity to 1024; the RAM is not cleared.
// The receiver cannot stall: o_done is high for exactly one cycle per item.
module binary_min_heap_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bmhq_pkg::t_cmd                i_cmd,
    output logic                          o_done,
    output bmhq_pkg::t_result             o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmhq_pkg::PADDR_W-1:0]  paddr,
    input  logic [bmhq_pkg::PDATA_W-1:0]  pwdata,
    output logic [bmhq_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DK_CMP,
        S_SU_CMP,
        S_WR_KEY,
        S_EX_RD,
        S_EX_CAP,
        S_SD_CMP
    } t_state;

    localparam int AW = bmhq_pkg::ADDR_W;
    localparam int IW = bmhq_pkg::IDX_W;
    localparam int CW = bmhq_pkg::CNT_W;
    localparam int KW = bmhq_pkg::KEY_W;

    t_state                r_state,  n_state;
    logic [CW-1:0]         r_cnt,    n_cnt;
    logic [CW-1:0]         r_cap;
    logic [AW-1:0]         r_idx,    n_idx;
    logic [AW-1:0]         r_par,    n_par;
    logic signed [KW-1:0]  r_key,    n_key;
    logic                  r_del,    n_del;
    logic                  r_done,   n_done;
    logic signed [KW-1:0]  r_value,  n_value;
    logic [bmhq_pkg::ST_W-1:0] r_status, n_status;

    // heap storage
    logic signed [KW-1:0]  mem [bmhq_pkg::DEPTH];
    logic signed [KW-1:0]  rd_a_data, rd_b_data;
    logic [AW-1:0]         rd_a_addr, rd_b_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic signed [KW-1:0]  wr_data;

    logic [CW-1:0]         limit;
    logic                  cfg_wr;
    logic [IW-1:0]         l_idx, r_idx_c, m_idx, nl_idx;
    logic                  sel_l, sel_r, l_ok, r_ok;
    logic signed [KW-1:0]  best;
    logic [CW-1:0]         cnt_dec;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == bmhq_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == bmhq_pkg::REG_CAPACITY)
                    ? bmhq_pkg::PDATA_W'(r_cap) : '0;

    assign limit   = (r_cap > bmhq_pkg::CNT_DEPTH) ? bmhq_pkg::CNT_DEPTH : r_cap;
    assign busy    = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_result.value  = r_value;
    assign o_result.status = r_status;
    assign o_result.count  = r_cnt;
    assign cnt_dec = r_cnt - CW'(1);

    // sift-down child selection
    assign l_idx   = {1'b0, r_idx, 1'b1};
    assign r_idx_c = l_idx + IW'(1);
    assign l_ok    = l_idx < IW'(r_cnt);
    assign r_ok    = r_idx_c < IW'(r_cnt);
    assign sel_l   = l_ok && (rd_a_data < r_key);
    assign best    = sel_l ? rd_a_data : r_key;
    assign sel_r   = r_ok && (rd_b_data < best);
    assign m_idx   = sel_r ? r_idx_c : l_idx;
    assign nl_idx  = {m_idx[IW-2:0], 1'b1};

    always_ff @(posedge i_clk) begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_par    = r_par;
        n_key    = r_key;
        n_del    = r_del;
        n_done   = 1'b0;
        n_value  = r_value;
        n_status = r_status;
        rd_a_addr = '0;
        rd_b_addr = '0;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = r_key;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_value  = '0;
                    n_status = bmhq_pkg::ST_OK;
                    n_key    = i_cmd.key;
                    n_del    = 1'b0;
                    case (i_cmd.opcode)
                        bmhq_pkg::OP_INSERT: begin
                            if (r_cnt >= limit) begin
                                n_status = bmhq_pkg::ST_FULL;
                                n_done   = 1'b1;
                            end else begin
                                n_cnt = r_cnt + CW'(1);
                                n_idx = r_cnt[AW-1:0];
                                n_par = (r_cnt[AW-1:0] - AW'(1)) >> 1;
                                rd_a_addr = (r_cnt[AW-1:0] - AW'(1)) >> 1;
                                n_state = (r_cnt == '0) ? S_WR_KEY : S_SU_CMP;
                            end
                        end
                        bmhq_pkg::OP_EXTRACT: begin
                            if (r_cnt == '0) begin
                                n_value  = bmhq_pkg::KEY_EMPTY;
                                n_status = bmhq_pkg::ST_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_EX_RD;
                            end
                        end
                        bmhq_pkg::OP_DECREASE, bmhq_pkg::OP_DELETE: begin
                            if (CW'(i_cmd.position) >= r_cnt) begin
                                n_status = bmhq_pkg::ST_BADIDX;
                                n_done   = 1'b1;
                            end else begin
                                n_idx = i_cmd.position;
                                n_par = (i_cmd.position - AW'(1)) >> 1;
                                if (i_cmd.opcode == bmhq_pkg::OP_DECREASE) begin
                                    rd_a_addr = i_cmd.position;
                                    n_state   = S_DK_CMP;
                                end else begin
                                    n_key = bmhq_pkg::KEY_MIN;
                                    n_del = 1'b1;
                                    rd_a_addr = (i_cmd.position - AW'(1)) >> 1;
                                    n_state = (i_cmd.position == '0) ? S_WR_KEY : S_SU_CMP;
                                end
                            end
                        end
                        bmhq_pkg::OP_CLEAR: begin
                            n_cnt  = '0;
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_DK_CMP: begin
                if (rd_a_data < r_key) begin
                    n_status = bmhq_pkg::ST_LARGER;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    rd_a_addr = r_par;
                    n_state   = (r_idx == '0) ? S_WR_KEY : S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                wr_en = 1'b1;
                if (r_key < rd_a_data) begin
                    // move parent down into the hole and climb
                    wr_data   = rd_a_data;
                    n_idx     = r_par;
                    n_par     = (r_par - AW'(1)) >> 1;
                    rd_a_addr = (r_par - AW'(1)) >> 1;
                    if (r_par == '0) begin
                        n_state = S_WR_KEY;
                    end
                end else if (r_del) begin
                    n_state = S_EX_RD;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WR_KEY: begin
                wr_en = 1'b1;
                if (r_del) begin
                    n_state = S_EX_RD;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EX_RD: begin
                rd_a_addr = '0;
                rd_b_addr = cnt_dec[AW-1:0];
                n_state   = S_EX_CAP;
            end
            S_EX_CAP: begin
                if (!r_del) begin
                    n_value = rd_a_data;
                end
                n_del = 1'b0;
                n_key = rd_b_data;
                n_cnt = cnt_dec;
                n_idx = '0;
                rd_a_addr = AW'(1);
                rd_b_addr = AW'(2);
                if (cnt_dec == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (cnt_dec == CW'(1)) begin
                    n_state = S_WR_KEY;
                end else begin
                    n_state = S_SD_CMP;
                end
            end
            S_SD_CMP: begin
                wr_en = 1'b1;
                if (sel_l || sel_r) begin
                    // pull the smaller child up into the hole and descend
                    wr_data   = sel_r ? rd_b_data : rd_a_data;
                    n_idx     = m_idx[AW-1:0];
                    rd_a_addr = nl_idx[AW-1:0];
                    rd_b_addr = nl_idx[AW-1:0] + AW'(1);
                    if (nl_idx >= IW'(r_cnt)) begin
                        n_state = S_WR_KEY;
                    end
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_cap    <= bmhq_pkg::CAP_RESET;
            r_del    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_del    <= n_del;
            r_done   <= n_done;
            if (cfg_wr) begin
                r_cap <= pwdata[CW-1:0];
            end
        end
        r_idx    <= n_idx;
        r_par    <= n_par;
        r_key    <= n_key;
        r_value  <= n_value;
        r_status <= n_status;
    end

endmodule

/* verif/tb_binary_min_heap_queue_core.sv */
// Testbench for binary_min_heap_queue_core: directed and random commands checked against a heap shadow.
module tb_binary_min_heap_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DEEP_FILL = 128;

    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST = 3'd7;
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam logic signed [KEY_W-1:0] KEY_MAX = ~KEY_MIN;

    // Shadow copy of the heap: predicts each result and checks the block against it.
    class min_heap_shadow;
        logic signed [KEY_W-1:0] keys [DEPTH];
        int unsigned n_keys;
        logic [CNT_W-1:0] capacity;
        t_result results_due [$];
        int unsigned mismatches;

        function new();
            n_keys = 0;
            capacity = CAP_RESET;
            mismatches = 0;
        endfunction

        function void swap_keys(input int unsigned a, input int unsigned b);
            logic signed [KEY_W-1:0] t;
            t = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        function void sift_up(input int unsigned idx);
            int unsigned i;
            int unsigned p;
            i = idx;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!(keys[i] < keys[p]))
                    break;
                swap_keys(i, p);
                i = p;
            end
        endfunction

        function void sift_down(input int unsigned idx);
            int unsigned i;
            int unsigned l;
            int unsigned r;
            int unsigned m;
            i = idx;
            forever begin
                l = 2 * i + 1;
                r = 2 * i + 2;
                m = i;
                if (l < n_keys && keys[l] < keys[m])
                    m = l;
                if (r < n_keys && keys[r] < keys[m])
                    m = r;
                if (m == i)
                    break;
                swap_keys(i, m);
                i = m;
            end
        endfunction

        function logic signed [KEY_W-1:0] pop_min();
            logic signed [KEY_W-1:0] top;
            top = keys[0];
            n_keys--;
            if (n_keys > 0) begin
                keys[0] = keys[n_keys];
                sift_down(0);
            end
            return top;
        endfunction

        function void note_accepted(input t_cmd c);
            t_result r;
            int unsigned lim;
            lim = (int'(capacity) < DEPTH) ? int'(capacity) : DEPTH;
            r.value = '0;
            r.status = ST_OK;
            case (c.opcode)
                OP_INSERT: begin
                    if (n_keys >= lim) begin
                        r.status = ST_FULL;
                    end else begin
                        keys[n_keys] = c.key;
                        n_keys++;
                        sift_up(n_keys - 1);
                    end
                end
                OP_EXTRACT: begin
                    if (n_keys == 0) begin
                        r.value = KEY_EMPTY;
                        r.status = ST_EMPTY;
                    end else begin
                        r.value = pop_min();
                    end
                end
                OP_DECREASE: begin
                    if (c.position >= n_keys) begin
                        r.status = ST_BADIDX;
                    end else if (keys[c.position] < c.key) begin
                        r.status = ST_LARGER;
                    end else begin
                        keys[c.position] = c.key;
                        sift_up(c.position);
                    end
                end
                OP_DELETE: begin
                    if (c.position >= n_keys) begin
                        r.status = ST_BADIDX;
                    end else begin
                        // float the entry to the root, then remove the root
                        keys[c.position] = KEY_MIN;
                        sift_up(c.position);
                        void'(pop_min());
                    end
                end
                OP_CLEAR: n_keys = 0;
                default: ;
            endcase
            r.count = CNT_W'(n_keys);
            results_due.push_back(r);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: value %0d status %0d count %0d",
                         $time, got.value, got.status, got.count);
                return;
            end
            want = results_due.pop_front();
            if (got.value !== want.value) begin
                mismatches++;
                $display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
            end
            if (got.status !== want.status) begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
            if (got.count !== want.count) begin
                mismatches++;
                $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_done;
    t_result o_result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    min_heap_shadow sb = new();
    int unsigned cycles = 0;
    int unsigned burst_left;

    binary_min_heap_queue_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_result);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("binary_min_heap_queue_core test failed");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input logic [OP_W-1:0] op,
                                      input logic signed [KEY_W-1:0] key,
                                      input int unsigned pos);
        t_cmd c;
        c.opcode = op;
        c.key = key;
        c.position = ADDR_W'(pos);
        return c;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return KEY_MIN;
        if (sel == 1)
            return KEY_MAX;
        // narrow range gives plenty of equal keys
        if (sel < 5)
            return KEY_W'(int'($urandom_range(0, 16)) - 8);
        return $urandom;
    endfunction

    // Pick a key no larger than cur, mostly close to it.
    function automatic logic signed [KEY_W-1:0] lower_key(input logic signed [KEY_W-1:0] cur);
        longint c;
        longint lo;
        c = cur;
        lo = c - 1000;
        if (lo < longint'(KEY_MIN))
            lo = longint'(KEY_MIN);
        return KEY_W'(lo + longint'($urandom_range(0, int'(c - lo))));
    endfunction

    function automatic t_cmd pick_command();
        t_cmd c;
        int unsigned sel;
        c.key = pick_key();
        c.position = ADDR_W'($urandom_range(0, DEPTH - 1));
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            c.opcode = OP_INSERT;
        end else if (sel < 62) begin
            c.opcode = OP_EXTRACT;
        end else if (sel < 77) begin
            c.opcode = OP_DECREASE;
            if (sb.n_keys > 0 && $urandom_range(0, 99) < 85) begin
                c.position = ADDR_W'($urandom_range(0, sb.n_keys - 1));
                if ($urandom_range(0, 3) != 0)
                    c.key = lower_key(sb.keys[c.position]);
            end
        end else if (sel < 90) begin
            c.opcode = OP_DELETE;
            if (sb.n_keys > 0 && $urandom_range(0, 99) < 85)
                c.position = ADDR_W'($urandom_range(0, sb.n_keys - 1));
        end else if (sel < 93) begin
            c.opcode = OP_CLEAR;
        end else begin
            c.opcode = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        end
        return c;
    endfunction

    task automatic send_item(input t_cmd c);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.note_accepted(c);
    endtask

    task automatic hold_off(input int unsigned n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Send one item, then idle between bursts of random length.
    task automatic issue(input t_cmd c);
        send_item(c);
        burst_left--;
        if (burst_left == 0) begin
            hold_off(($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.results_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            sb.mismatches++;
            $display("%0t: register read expected %0d actual %0d", $time, want, got);
        end
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        wait_results_done();
        apb_write(CAPACITY_ADDR, PDATA_W'(cap));
        sb.capacity = cap;
        apb_read_check(CAPACITY_ADDR, PDATA_W'(cap));
    endtask

    task automatic run_random(input int unsigned n_items);
        for (int unsigned k = 0; k < n_items; k++) begin
            issue(pick_command());
            // let the block run dry now and then
            if ($urandom_range(0, 49) == 0)
                wait_results_done();
        end
    endtask

    task automatic run_directed();
        issue(make_cmd(OP_EXTRACT, $urandom, $urandom_range(0, DEPTH - 1)));
        issue(make_cmd(OP_DECREASE, KEY_MIN, 0));
        issue(make_cmd(OP_DELETE, KEY_MAX, 0));
        issue(make_cmd(OP_INSERT, KEY_MAX, 0));
        issue(make_cmd(OP_INSERT, 0, DEPTH - 1));
        issue(make_cmd(OP_INSERT, KEY_MIN, 0));
        issue(make_cmd(OP_INSERT, KEY_EMPTY, 0));
        issue(make_cmd(OP_INSERT, 5, 0));
        issue(make_cmd(OP_INSERT, 5, 0));
        issue(make_cmd(OP_DECREASE, KEY_MAX, 5));
        issue(make_cmd(OP_DECREASE, sb.keys[2], 2));
        issue(make_cmd(OP_DECREASE, KEY_MIN, 4));
        issue(make_cmd(OP_DELETE, 0, DEPTH - 1));
        issue(make_cmd(OP_DELETE, 0, 1));
        issue(make_cmd(OP_RSVD_FIRST, KEY_MAX, DEPTH - 1));
        issue(make_cmd(OP_RSVD_LAST, KEY_MIN, 0));
        issue(make_cmd(OP_EXTRACT, 0, 0));
        issue(make_cmd(OP_EXTRACT, 0, 0));
        issue(make_cmd(OP_CLEAR, $urandom, $urandom_range(0, DEPTH - 1)));
        issue(make_cmd(OP_EXTRACT, 0, 0));
        set_capacity('0);
        issue(make_cmd(OP_INSERT, 1, 0));
        set_capacity(CNT_W'(1));
        issue(make_cmd(OP_INSERT, KEY_MAX, 0));
        issue(make_cmd(OP_INSERT, 7, 0));
        issue(make_cmd(OP_DECREASE, KEY_MIN, 0));
        issue(make_cmd(OP_EXTRACT, 0, 0));
    endtask

    // Grow a deeper heap with capacity above the depth, then work on it.
    task automatic run_deep_heap();
        set_capacity('1);
        while (sb.n_keys < DEEP_FILL)
            issue(make_cmd(OP_INSERT, $urandom, $urandom_range(0, DEPTH - 1)));
        issue(make_cmd(OP_DECREASE, KEY_MIN, DEEP_FILL - 1));
        for (int unsigned k = 0; k < 30; k++) begin
            if ($urandom_range(0, 1) == 0)
                issue(make_cmd(OP_DELETE, pick_key(), $urandom_range(0, DEEP_FILL - 1)));
            else
                issue(make_cmd(OP_DECREASE, pick_key(), $urandom_range(0, DEEP_FILL - 1)));
        end
        repeat (20) issue(make_cmd(OP_EXTRACT, $urandom, $urandom_range(0, DEPTH - 1)));
        issue(make_cmd(OP_CLEAR, 0, 0));
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_read_check(CAPACITY_ADDR, PDATA_W'(CAP_RESET));
        run_directed();

        set_capacity(CNT_W'($urandom_range(2, 12)));
        run_random(60);
        run_deep_heap();
        set_capacity(CNT_W'(3));
        run_random(40);
        set_capacity(CNT_DEPTH);
        run_random(60);
        set_capacity(CNT_W'($urandom_range(8, 40)));
        run_random(40);

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.results_due.size() == 0)
            $display("binary_min_heap_queue_core test passed");
        else
            $display("binary_min_heap_queue_core test failed");
        $finish;
    end

endmodule

/* binary_min_heap_queue_core.f */
hw/rtl/bmhq_pkg.sv
hw/rtl/binary_min_heap_queue_core.sv
verif/tb_binary_min_heap_queue_core.sv
